// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Text console writer package
// Shared types, codes and constants of the text console writer.
// ============================================================================
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'hFF;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } ctl_state_t;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } sweep_kind_t;

    typedef struct packed {
        logic              take;
        logic [MODE_W-1:0] mode;
        logic              sweep_start;
        sweep_kind_t       sweep_kind;
        logic              sweep_run;
        logic              out_load;
        logic              out_from_read;
    } ctl_cmd_t;

    typedef struct packed {
        logic put_scroll;
        logic sweep_done;
    } dp_status_t;

endpackage

// ===== hdl/tcw_req_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Text console writer request channel
// Valid/ready channel that carries one console command item.
// ============================================================================
interface tcw_req_if;
    import tcw_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, output mode, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input mode, input char_code, input cell_index,
                  output ready);
endinterface

// ===== hdl/tcw_rsp_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Text console writer response channel
// Valid/ready channel that carries one cursor and cell result item.
// ============================================================================
interface tcw_rsp_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_position, output cell_value, input ready);
    modport sink (input valid, input cursor_col, input cursor_row,
                  input cursor_position, input cell_value, output ready);
endinterface

// ===== hdl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Text console writer controller
// Sequences reset clearing, item acceptance, cell reads, sweeps and results.
// ============================================================================
module tcw_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic [tcw_pkg::MODE_W-1:0] req_mode,
    output logic                      req_ready,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  tcw_pkg::dp_status_t       status,
    output tcw_pkg::ctl_cmd_t         cmd
);
    import tcw_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       ready_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mode       = req_mode;
        cmd.sweep_kind = SW_SCROLL;
        cmd.sweep_run  = (state_reg == ST_INIT) || (state_reg == ST_SWEEP);
        ready_w        = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ready_w = !out_valid_reg || rsp_ready;
                if (req_valid && ready_w)
                begin
                    cmd.take = 1'b1;
                    case (req_mode)
                        MODE_PUT:
                        begin
                            if (status.put_scroll)
                            begin
                                cmd.sweep_start = 1'b1;
                                cmd.sweep_kind  = SW_SCROLL;
                                state_next      = ST_SWEEP;
                            end
                            else
                            begin
                                cmd.out_load = 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            state_next = ST_READ;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_kind  = SW_CLEAR;
                            state_next      = ST_SWEEP;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.out_load      = 1'b1;
                cmd.out_from_read = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (status.sweep_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign req_ready = ready_w;
    assign rsp_valid = out_valid_reg;

endmodule

// ===== hdl/tcw_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Text console writer datapath
// Screen store, cursor, attribute register and the sweep engine.
// ============================================================================
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
    input  tcw_pkg::ctl_cmd_t           cmd,
    output tcw_pkg::dp_status_t         status,
    output logic [tcw_pkg::COL_W-1:0]   cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::POS_W-1:0]   cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  cell_value
);
    import tcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(CELLS + 1);
    localparam int MOVE_CNT = CELLS - COLUMNS;

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    logic [ATTR_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [CW-1:0]     sweep_cnt_reg;
    sweep_kind_t       sweep_kind_reg;
    logic              pend_valid_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic              pend_blank_reg;
    logic              hit_reg;
    logic [CELL_W-1:0] cell_val_reg;

    logic [COL_W:0]    col_a;
    logic [ROW_W:0]    row_a;
    logic [ROW_W:0]    row_f;
    logic              printable;
    logic              scroll;
    logic              issue;
    logic              move;
    logic [AW-1:0]     cursor_addr;
    logic [CELL_W-1:0] fill_cell;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic              put_we;

    always_comb
    begin
        col_a     = {1'b0, col_reg};
        row_a     = {1'b0, row_reg};
        printable = 1'b0;
        case (char_code) inside
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_a = {1'b0, col_reg} - 1'b1;
                end
            end
            CH_TAB:
            begin
                col_a = ({1'b0, col_reg} + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
            end
            CH_CR:
            begin
                col_a = '0;
            end
            CH_LF:
            begin
                col_a = '0;
                row_a = {1'b0, row_reg} + 1'b1;
            end
            [CH_SPACE:CH_LAST]:
            begin
                printable = 1'b1;
                col_a     = {1'b0, col_reg} + 1'b1;
            end
            default:
            begin
                col_a = {1'b0, col_reg};
            end
        endcase
        if (col_a >= (COL_W + 1)'(COLUMNS))
        begin
            col_a = '0;
            row_a = {1'b0, row_reg} + 1'b1;
        end
        scroll = row_a >= (ROW_W + 1)'(ROWS);
        row_f  = scroll ? (ROW_W + 1)'(ROWS - 1) : row_a;
    end

    assign cursor_addr = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign fill_cell   = (sweep_kind_reg == SW_INIT) ? RESET_CELL : {attr_reg, CH_SPACE};
    assign issue       = cmd.sweep_run && (sweep_cnt_reg < CW'(CELLS));
    assign move        = (sweep_kind_reg == SW_SCROLL) && (sweep_cnt_reg < CW'(MOVE_CNT));
    assign put_we      = cmd.take && (cmd.mode == MODE_PUT) && printable;

    always_comb
    begin
        mem_raddr = issue ? (AW'(sweep_cnt_reg) + AW'(COLUMNS)) : AW'(cell_index);
        mem_we    = pend_valid_reg || put_we;
        if (pend_valid_reg)
        begin
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_blank_reg ? fill_cell : rd_data_reg;
        end
        else
        begin
            mem_waddr = cursor_addr;
            mem_wdata = {attr_reg, char_code};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= screen_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg       <= RESET_ATTR;
            col_reg        <= '0;
            row_reg        <= '0;
            sweep_cnt_reg  <= '0;
            sweep_kind_reg <= SW_INIT;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (cmd.take && (cmd.mode == MODE_PUT))
            begin
                col_reg <= col_a[COL_W-1:0];
                row_reg <= row_f[ROW_W-1:0];
            end
            else if (cmd.take && (cmd.mode == MODE_CLEAR))
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            if (cmd.take)
            begin
                hit_reg <= 32'(cell_index) < 32'(CELLS);
            end
            if (cmd.sweep_start)
            begin
                sweep_cnt_reg  <= '0;
                sweep_kind_reg <= cmd.sweep_kind;
            end
            else if (issue)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            pend_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_addr_reg  <= AW'(sweep_cnt_reg);
            pend_blank_reg <= !move;
        end
        if (cmd.out_load)
        begin
            cell_val_reg <= (cmd.out_from_read && hit_reg) ? rd_data_reg : '0;
        end
    end

    assign status.put_scroll = scroll;
    assign status.sweep_done = (sweep_cnt_reg == CW'(CELLS)) && !pend_valid_reg;

    assign cursor_col      = col_reg;
    assign cursor_row      = row_reg;
    assign cursor_position = POS_W'(cursor_addr);
    assign cell_value      = cell_val_reg;

endmodule

// ===== hdl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Text console writer core
// Character-cell console: put, read and clear over a screen store with cursor.
// ============================================================================
// Channel    Dir  Handshake     Payload
// request    in   valid/ready   mode, char_code, cell_index
// response   out  valid/ready   cursor_col, cursor_row, cursor_position, cell_value
// cfg        in   write enable  cfg_wdata (attribute byte)
//
// A put without scroll gives its result in the cycle after acceptance; a read first passes the READ state.
// A scroll or clear walks the screen store one cell a cycle, over all COLUMNS*ROWS cells.
// After reset a clearing pass over all COLUMNS*ROWS cells holds request.ready low.
// One item is worked at a time; the next is taken once the result register is free.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tcw_req_if.sink                    request,
    tcw_rsp_if.source                  response,
    input  logic                       cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
    import tcw_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_mode  (request.mode),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .char_code       (request.char_code),
        .cell_index      (request.cell_index),
        .cmd             (cmd),
        .status          (status),
        .cursor_col      (response.cursor_col),
        .cursor_row      (response.cursor_row),
        .cursor_position (response.cursor_position),
        .cell_value      (response.cell_value)
    );

`ifndef ASSERT_OFF
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(response.cursor_row) < ROWS)
        else $error("Cursor row is past the last row.");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(response.cursor_col) < COLUMNS)
        else $error("Cursor column is past the last column.");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.mode == MODE_READ))
        |=> !response.valid ##1 response.valid)
        else $error("A read item did not give its result after two cycles.");

    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.mode != MODE_READ)
         && (request.mode != MODE_PUT) && (request.mode != MODE_CLEAR))
        |=> response.valid && (response.cell_value == '0))
        else $error("An ignored item did not give a zero result at once.");
`endif

endmodule
